FILE: hdl/wmod_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmod_pkg
// Shared types and constants for the window midrange open detector.
// ----------------------------------------------------------------------------
package wmod_pkg;

	localparam int WIN_DEPTH = 60;   // samples kept in the window
	localparam int MIN_FILL  = 5;    // samples needed before a closed verdict
	localparam int AREA_W    = 16;   // unsigned Q8.8
	localparam int IDX_W     = $clog2(WIN_DEPTH);
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam logic [AREA_W-1:0] MIN_SEED_RST = 16'd25344;   // 99.0

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_CLEAR  = 1'b1
	} wmod_cmd_t;

	typedef struct packed {
		logic              cmd;
		logic [AREA_W-1:0] area_sample;
	} wmod_in_t;

	typedef struct packed {
		logic              is_open;
		logic [AREA_W-1:0] latest_area;
	} wmod_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} wmod_state_t;

endpackage : wmod_pkg
`default_nettype wire

FILE: hdl/wmod_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmod_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmod_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 60
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule : wmod_ram
`default_nettype wire

FILE: hdl/window_midrange_open_detector_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_midrange_open_detector_top
// Judges an opening open or closed from its area against the midrange of a
// window of the last WIN_DEPTH area samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one word per sample
//   or clear command. Output channel (out_valid / out_stall / out_word) gives
//   exactly one word per input word, in order.
//   cfg_we / cfg_data load min_seed; write it only while the block is idle.
// Sequence:
//   A sample word on a window holding N samples is scanned over its N slots
//   (one RAM read per cycle through the single read port), then passes a
//   drain step for the registered read and a write/evaluate step, then the
//   result is offered. An empty window goes straight to the write/evaluate
//   step; a clear command goes straight to the done state.
//   One word is in flight at a time; in_stall is high until the result is
//   taken, so a new word is accepted only once the last one is through.
// Reset:
//   arst_n clears the window (count and write slot to 0), the open flag to
//   closed and min_seed to 99.0. Window RAM contents are not cleared; only
//   slots already written are ever read.
// Backpressure:
//   While out_stall is high the result word holds and no new word is taken.
// ----------------------------------------------------------------------------
module window_midrange_open_detector_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire wmod_pkg::wmod_in_t        in_word,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output wmod_pkg::wmod_out_t            out_word,
	input  wire logic                      cfg_we,
	input  wire logic [wmod_pkg::AREA_W-1:0] cfg_data
);

	import wmod_pkg::*;

	wmod_state_t state_q, state_nxt;

	logic [AREA_W-1:0] min_seed_q;
	logic [CNT_W-1:0]  held_count_q;
	logic [IDX_W-1:0]  write_slot_q;
	logic              open_flag_q;
	logic [AREA_W-1:0] area_q;
	logic [AREA_W-1:0] hi_q;
	logic [AREA_W-1:0] lo_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_vld_s1;
	wmod_out_t         out_q;
	logic              out_valid_q;

	logic [AREA_W-1:0] ram_rdata;
	logic              ram_we;
	logic              in_acc;
	logic              out_acc;
	logic              scan_last;
	logic [CNT_W-1:0]  held_next;
	logic [AREA_W:0]   mid_sum;
	logic [AREA_W+3:0] lhs;
	logic [AREA_W+3:0] rhs;
	logic              closed;

	wmod_ram #(
		.WIDTH(AREA_W),
		.DEPTH(WIN_DEPTH)
	) u_win_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (write_slot_q),
		.wdata (area_q),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign scan_last = (CNT_W'(rd_idx_q) == held_count_q - CNT_W'(1));

	// held count after the append saturates at the window depth
	assign held_next = (held_count_q == CNT_W'(WIN_DEPTH)) ? held_count_q
	                                                      : held_count_q + CNT_W'(1);

	// closed when more than MIN_FILL samples are held after the append and 5*(max+min) > 12*area
	assign mid_sum = {1'b0, hi_q} + {1'b0, lo_q};
	assign lhs     = {1'b0, mid_sum, 2'b00} + {3'b000, mid_sum};
	assign rhs     = {1'b0, area_q, 3'b000} + {2'b00, area_q, 2'b00};
	assign closed  = (held_next > CNT_W'(MIN_FILL)) && (lhs > rhs);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_word.cmd == CMD_CLEAR) begin
						state_nxt = ST_DONE;
					end else if (held_count_q == '0) begin
						state_nxt = ST_WRITE;
					end else begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: state_nxt = ST_WRITE;
			ST_WRITE: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_acc) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall = 1'b1;
		ram_we   = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_WRITE: ram_we   = 1'b1;
			default: begin
				in_stall = 1'b1;
				ram_we   = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			min_seed_q   <= MIN_SEED_RST;
			held_count_q <= '0;
			write_slot_q <= '0;
			open_flag_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (cfg_we) begin
				min_seed_q <= cfg_data;
			end
			if (in_acc && in_word.cmd == CMD_CLEAR) begin
				held_count_q <= '0;
				write_slot_q <= '0;
				out_valid_q  <= 1'b1;
			end
			if (state_q == ST_WRITE) begin
				held_count_q <= held_next;
				write_slot_q <= (write_slot_q == IDX_W'(WIN_DEPTH - 1)) ? '0
				                                                        : write_slot_q + IDX_W'(1);
				open_flag_q  <= !closed;
				out_valid_q  <= 1'b1;
			end
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: scan index, running max/min, result word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			area_q   <= in_word.area_sample;
			hi_q     <= '0;
			lo_q     <= min_seed_q;
			rd_idx_q <= '0;
			if (in_word.cmd == CMD_CLEAR) begin
				out_q.is_open     <= open_flag_q;
				out_q.latest_area <= '0;
			end
		end
		if (state_q == ST_SCAN) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
		if (rd_vld_s1) begin
			if (ram_rdata > hi_q) begin
				hi_q <= ram_rdata;
			end
			if (ram_rdata < lo_q) begin
				lo_q <= ram_rdata;
			end
		end
		if (state_q == ST_WRITE) begin
			out_q.is_open     <= !closed;
			out_q.latest_area <= area_q;
		end
	end

	// Assertions
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CNT_W'(WIN_DEPTH))
		else $error("held count beyond window depth");

	a_slot_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(held_count_q < CNT_W'(WIN_DEPTH)) |-> (CNT_W'(write_slot_q) == held_count_q))
		else $error("write slot out of step with held count");

	a_out_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_DONE))
		else $error("result offered outside done state");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("read data valid outside scan");

	a_taken_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |=> (!out_valid && state_q == ST_IDLE))
		else $error("result not retired after being taken");

endmodule : window_midrange_open_detector_top
`default_nettype wire
